// ----- rtl/opwf_pkg.sv -----
// Package for the oil-paint window filter: word types and fixed constants.
// Used by the filter top level and its testbench; depends on nothing.
package opwf_pkg;

   // Input word: load or query.
   typedef struct packed {
      logic        kind;
      logic [5:0]  x;
      logic [5:0]  y;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [5:0]  out_x;
      logic [5:0]  out_y;
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [15:0] out_alpha;
   } rsp_type;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [2:0] CSR_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_RADIUS  = 3'd2;
   localparam logic [2:0] CSR_LEVELS  = 3'd3;
   localparam logic [2:0] CSR_SIXTEEN = 3'd4;

   // Luminance weights and scale terms.
   localparam int unsigned LUM_R = 30;
   localparam int unsigned LUM_G = 59;
   localparam int unsigned LUM_B = 11;
   localparam logic [31:0] DEN8  = 32'd25500;
   localparam logic [31:0] DEN16 = 32'd6553500;
   localparam logic [31:0] HALF8  = 32'd12750;
   localparam logic [31:0] HALF16 = 32'd3276750;

   // Reciprocals floor(2^31 / denominator). For a numerator below 2^31 the
   // scaled product gives the bin or one less, so one compare fixes it.
   localparam logic [31:0] RECIP8  = 32'd84215;
   localparam logic [31:0] RECIP16 = 32'd327;

endpackage

// ----- rtl/opwf_divider.sv -----
// Restoring divider, one quotient bit per cycle, used for the three mean divisions.
// Self-contained; depends on no package.
module opwf_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   // One shift-subtract step per cycle.
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (go) begin
         q_in = numer; r_in = '0; d_in = denom;
         cnt_in = CW'(NUM_W); run_in = 1'b1;
      end else if (run_ff) begin
         q_in = {q_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ----- rtl/oil_paint_window_filter.sv -----
// Oil-paint window filter top level: frame store, bin memory and query sequencer.
// Depends on opwf_pkg and opwf_divider.
// A load is taken without leaving idle, so loads can follow back to back. A query holds
// busy while it clears the bins, walks the window and scans the bins, and, when a winning
// bin holds a pixel, while it runs the three mean divisions. The word comes in the same
// cycle that busy falls. Reset is synchronous; the frame store is not cleared. Results
// cannot be stalled.
module oil_paint_window_filter #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_RADIUS = 7,
   parameter int MAX_LEVELS = 255
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  opwf_pkg::req_type req_word,
   output logic              rsp_strobe,
   output opwf_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import opwf_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = XW + YW;
   localparam int BW = $clog2(MAX_LEVELS + 1);
   localparam int NBIN = MAX_LEVELS + 1;

   localparam logic [4:0] S_IDLE = 5'd0, S_CLEAR = 5'd1, S_ADDR = 5'd2, S_RD = 5'd3,
      S_LUM = 5'd4, S_NUM = 5'd5, S_MUL = 5'd6, S_EST = 5'd7, S_FIX = 5'd8,
      S_BRD = 5'd9, S_BWR = 5'd10, S_SCAN = 5'd11, S_SCANW = 5'd12, S_DR = 5'd13,
      S_DG = 5'd14, S_DB = 5'd15, S_OUT = 5'd16, S_ALPHA = 5'd17;

   // Configuration registers.
   logic [6:0] width_ff, height_ff;
   logic [2:0] radius_ff;
   logic [7:0] levels_ff;
   logic       sixteen_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd64; height_ff <= 7'd64; radius_ff <= 3'd1;
         levels_ff <= 8'd30; sixteen_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:   width_ff   <= csr_data[6:0];
            CSR_HEIGHT:  height_ff  <= csr_data[6:0];
            CSR_RADIUS:  radius_ff  <= csr_data[2:0];
            CSR_LEVELS:  levels_ff  <= csr_data;
            CSR_SIXTEEN: sixteen_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective limits.
   logic [12:0] wid, hgt;
   logic [2:0]  rad;
   logic [7:0]  lev;
   always_comb begin
      wid = (13'(width_ff) < 13'(MAX_WIDTH)) ? 13'(width_ff) : 13'(MAX_WIDTH);
      hgt = (13'(height_ff) < 13'(MAX_HEIGHT)) ? 13'(height_ff) : 13'(MAX_HEIGHT);
      rad = (radius_ff < 3'(MAX_RADIUS)) ? radius_ff : 3'(MAX_RADIUS);
      lev = (levels_ff < 8'(MAX_LEVELS)) ? levels_ff : 8'(MAX_LEVELS);
   end

   // Frame store memory.
   logic [63:0] frame_mem [2**AW];
   logic [63:0] frame_q_ff;
   logic        frame_we;
   logic [AW-1:0] frame_waddr, frame_raddr;
   always_ff @(posedge clock) begin
      if (frame_we) frame_mem[frame_waddr] <= {req_word.alpha, req_word.blue,
                                               req_word.green, req_word.red};
      frame_q_ff <= frame_mem[frame_raddr];
   end

   // Bin memory: count and three sums per bin.
   logic [79:0] bin_mem [NBIN];
   logic [79:0] bin_q_ff, bin_wdata;
   logic        bin_we;
   logic [BW-1:0] bin_waddr, bin_raddr;
   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
      bin_q_ff <= bin_mem[bin_raddr];
   end

   // Sequencer state.
   logic [4:0]  state_ff, state_in;
   logic [5:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [7:0] wx_ff, wx_in, wy_ff, wy_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic [7:0]  bestc_ff, bestc_in;
   logic [15:0] r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [23:0] lum_ff, lum_in;
   logic [30:0] num_ff, num_in;
   logic [47:0] prod_ff, prod_in;
   logic [7:0]  qe_ff, qe_in;
   logic [30:0] qd_ff, qd_in;
   logic [31:0] den_c;
   logic [8:0]  q_fix;
   logic [BW-1:0] bin_ff, bin_in;
   logic [15:0] or_ff, or_in, og_ff, og_in, ob_ff, ob_in, oa_ff, oa_in;
   logic [23:0] sr_ff, sr_in, sg_ff, sg_in, sb_ff, sb_in;
   logic        strobe_ff, strobe_in;
   logic        div_go;
   logic [23:0] div_num;
   logic [7:0]  div_den;
   logic        div_done;
   logic [23:0] div_q;

   opwf_divider #(.NUM_W(24), .DEN_W(8)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .numer(div_num),
      .denom(div_den), .done(div_done), .quot(div_q)
   );

   logic in_img;
   logic [7:0] last_w, last_h;
   assign in_img = (wx_ff >= 0) && (wy_ff >= 0) &&
                   (13'(unsigned'(wx_ff)) < wid) && (13'(unsigned'(wy_ff)) < hgt);

   always_comb begin
      state_in = state_ff; qx_in = qx_ff; qy_in = qy_ff; wx_in = wx_ff; wy_in = wy_ff;
      idx_in = idx_ff; bestc_in = bestc_ff;
      r_in = r_ff; g_in = g_ff; b_in = b_ff; lum_in = lum_ff; bin_in = bin_ff;
      num_in = num_ff; prod_in = prod_ff; qe_in = qe_ff; qd_in = qd_ff;
      or_in = or_ff; og_in = og_ff; ob_in = ob_ff; oa_in = oa_ff;
      sr_in = sr_ff; sg_in = sg_ff; sb_in = sb_ff; strobe_in = 1'b0;
      frame_we = 1'b0;
      frame_waddr = {YW'(req_word.y), XW'(req_word.x)};
      frame_raddr = {YW'(unsigned'(wy_ff)), XW'(unsigned'(wx_ff))};
      bin_we = 1'b0; bin_waddr = bin_ff; bin_raddr = idx_ff; bin_wdata = '0;
      div_go = 1'b0; div_num = '0;
      div_den = bestc_ff;
      den_c = sixteen_ff ? DEN16 : DEN8;
      q_fix = {1'b0, qe_ff};
      last_w = 8'(signed'({2'b0, qx_ff})) + 8'(rad);
      last_h = 8'(signed'({2'b0, qy_ff})) + 8'(rad);
      unique case (state_ff)
         S_IDLE: if (start) begin
            if (req_word.kind == KIND_LOAD) begin
               frame_we = (32'(req_word.x) < MAX_WIDTH) && (32'(req_word.y) < MAX_HEIGHT);
            end else begin
               qx_in = req_word.x; qy_in = req_word.y;
               idx_in = '0; state_in = S_CLEAR;
            end
         end
         // Clear every bin, one per cycle.
         S_CLEAR: begin
            bin_we = 1'b1; bin_waddr = idx_ff; bin_wdata = '0;
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == NBIN - 1) begin
               wx_in = 8'(qx_ff) - 8'(rad); wy_in = 8'(qy_ff) - 8'(rad);
               state_in = S_ADDR;
            end
         end
         // Walk the window column by column.
         S_ADDR: state_in = in_img ? S_RD : S_BWR;
         S_RD: state_in = S_LUM;
         S_LUM: begin
            r_in = sixteen_ff ? frame_q_ff[15:0] : {8'd0, frame_q_ff[7:0]};
            g_in = sixteen_ff ? frame_q_ff[31:16] : {8'd0, frame_q_ff[23:16]};
            b_in = sixteen_ff ? frame_q_ff[47:32] : {8'd0, frame_q_ff[39:32]};
            lum_in = 24'(r_in) * 24'(LUM_R) + 24'(g_in) * 24'(LUM_G) +
                     24'(b_in) * 24'(LUM_B);
            state_in = S_NUM;
         end
         // Scale the luminance to the level range and add the rounding half.
         S_NUM: begin
            num_in = 31'(lum_ff) * 31'(lev) + 31'(sixteen_ff ? HALF16 : HALF8);
            state_in = S_MUL;
         end
         // Estimate the bin by reciprocal multiplication.
         S_MUL: begin
            prod_in = 48'(num_ff) * 48'(sixteen_ff ? RECIP16 : RECIP8);
            state_in = S_EST;
         end
         S_EST: begin
            qe_in = prod_ff[38:31];
            qd_in = 31'(prod_ff[38:31]) * 31'(den_c);
            state_in = S_FIX;
         end
         // The estimate is at most one low; one compare settles it.
         S_FIX: begin
            if (32'(num_ff) >= 32'(qd_ff) + den_c) q_fix = {1'b0, qe_ff} + 9'd1;
            bin_in = (q_fix > 9'(lev)) ? BW'(lev) : BW'(q_fix);
            idx_in = (q_fix > 9'(lev)) ? BW'(lev) : BW'(q_fix);
            state_in = S_BRD;
         end
         S_BRD: state_in = S_BWR;
         S_BWR: begin
            if (in_img) begin
               bin_we = 1'b1;
               bin_wdata = {bin_q_ff[79:72] + 8'd1, bin_q_ff[71:48] + 24'(r_ff),
                            bin_q_ff[47:24] + 24'(g_ff), bin_q_ff[23:0] + 24'(b_ff)};
            end
            if (wy_ff == signed'(last_h)) begin
               wy_in = 8'(qy_ff) - 8'(rad);
               wx_in = wx_ff + 8'sd1;
               if (wx_ff == signed'(last_w)) begin
                  idx_in = '0; bestc_in = '0; state_in = S_SCAN;
               end else state_in = S_ADDR;
            end else begin
               wy_in = wy_ff + 8'sd1; state_in = S_ADDR;
            end
         end
         // Scan bins for the first maximum.
         S_SCAN: state_in = S_SCANW;
         S_SCANW: begin
            if (bin_q_ff[79:72] > bestc_ff) begin
               bestc_in = bin_q_ff[79:72];
               sr_in = bin_q_ff[71:48]; sg_in = bin_q_ff[47:24]; sb_in = bin_q_ff[23:0];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == BW'(lev)) begin
               or_in = '0; og_in = '0; ob_in = '0;
               state_in = (bestc_in == 8'd0) ? S_ALPHA : S_DR;
               div_go = (bestc_in != 8'd0);
               div_num = sr_in;
               div_den = bestc_in;
            end else state_in = S_SCAN;
         end
         S_DR: begin
            if (div_done) begin
               or_in = div_q[15:0]; div_go = 1'b1; div_num = sg_ff; state_in = S_DG;
            end
         end
         S_DG: begin
            if (div_done) begin
               og_in = div_q[15:0]; div_go = 1'b1; div_num = sb_ff; state_in = S_DB;
            end
         end
         S_DB: begin
            if (div_done) begin
               ob_in = div_q[15:0]; state_in = S_ALPHA;
            end
         end
         // Read the center pixel for alpha.
         S_ALPHA: begin
            frame_raddr = {YW'(qy_ff), XW'(qx_ff)};
            state_in = S_OUT;
         end
         S_OUT: begin
            oa_in = ((32'(qx_ff) < MAX_WIDTH) && (32'(qy_ff) < MAX_HEIGHT)) ?
                    (sixteen_ff ? frame_q_ff[63:48] : {8'd0, frame_q_ff[55:48]}) : 16'd0;
            strobe_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in; qy_ff <= qy_in; wx_ff <= wx_in; wy_ff <= wy_in;
      idx_ff <= idx_in; bestc_ff <= bestc_in;
      r_ff <= r_in; g_ff <= g_in; b_ff <= b_in; lum_ff <= lum_in; bin_ff <= bin_in;
      num_ff <= num_in; prod_ff <= prod_in; qe_ff <= qe_in; qd_ff <= qd_in;
      or_ff <= or_in; og_ff <= og_in; ob_ff <= ob_in; oa_ff <= oa_in;
      sr_ff <= sr_in; sg_ff <= sg_in; sb_ff <= sb_in;
      if (reset) begin
         state_ff <= S_IDLE; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; strobe_ff <= strobe_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word = '{out_x: qx_ff, out_y: qy_ff, out_red: or_ff, out_green: og_ff,
                       out_blue: ob_ff, out_alpha: oa_ff};

   // A result follows only the final state of a query.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_OUT) else $error("strobe without query end");
   // The block is idle when it reports a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("busy with result");
   // A winning bin always holds a pixel before division starts.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DR |-> bestc_ff != 8'd0) else $error("empty winning bin");
endmodule

// ----- test/oil_paint_window_filter_test.sv -----
// Self-checking testbench for the oil-paint window filter: loads pixels, queries
// filtered pixels under several register settings and checks each result word.
// Depends on opwf_pkg and the oil_paint_window_filter RTL.
`timescale 1ns / 1ps

module oil_paint_window_filter_test;
   import opwf_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   oil_paint_window_filter u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state: our own copy of the frame store and the registers.
   logic [63:0] pixel_mem [4096];
   bit          pixel_loaded [4096];
   logic [6:0]  cur_width;
   logic [6:0]  cur_height;
   logic [2:0]  cur_radius;
   logic [7:0]  cur_levels;
   logic        cur_sixteen;

   req_type pending_words [$];
   rsp_type painted_expect [$];
   int      accepted_cnt;
   int      issued_cnt;
   int      burst_left;
   int      gap_left;
   bit      failed;

   always #1 clock = ~clock;

   // A channel as the block sees it: 8-bit mode keeps only the low byte.
   function automatic int unsigned channel_of(logic [63:0] px, int k);
      logic [15:0] v;
      v = px[16*k +: 16];
      return cur_sixteen ? v : {8'd0, v[7:0]};
   endfunction

   // Oil-paint result for one query word, from the current store and registers.
   function automatic rsp_type paint_pixel(req_type q);
      int unsigned cnt [256];
      int unsigned sum_r [256];
      int unsigned sum_g [256];
      int unsigned sum_b [256];
      int wid;
      int hgt;
      int rad;
      int unsigned lev;
      longint unsigned maxv;
      longint unsigned lum;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      int unsigned bin;
      int unsigned best;
      int unsigned best_cnt;
      logic [63:0] px;
      rsp_type res;
      wid = cur_width > 64 ? 64 : cur_width;
      hgt = cur_height > 64 ? 64 : cur_height;
      rad = cur_radius;
      lev = cur_levels;
      maxv = cur_sixteen ? 65535 : 255;
      for (int i = 0; i < 256; i++) begin
         cnt[i] = 0; sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0;
      end
      for (int wx = int'(q.x) - rad; wx <= int'(q.x) + rad; wx++) begin
         for (int wy = int'(q.y) - rad; wy <= int'(q.y) + rad; wy++) begin
            if (wx >= 0 && wx < wid && wy >= 0 && wy < hgt) begin
               px = pixel_mem[wy * 64 + wx];
               r = channel_of(px, 0);
               g = channel_of(px, 1);
               b = channel_of(px, 2);
               lum = 30 * r + 59 * g + 11 * b;
               bin = int'((lum * lev + 50 * maxv) / (100 * maxv));
               if (bin > lev) bin = lev;
               cnt[bin]++;
               sum_r[bin] += r;
               sum_g[bin] += g;
               sum_b[bin] += b;
            end
         end
      end
      // Ties go to the lowest bin, so only a strictly larger count wins.
      best = 0;
      best_cnt = 0;
      for (int i = 0; i <= int'(lev); i++) begin
         if (cnt[i] > best_cnt) begin
            best_cnt = cnt[i];
            best = i;
         end
      end
      res.out_x = q.x;
      res.out_y = q.y;
      res.out_red = best_cnt != 0 ? 16'(sum_r[best] / best_cnt) : 16'd0;
      res.out_green = best_cnt != 0 ? 16'(sum_g[best] / best_cnt) : 16'd0;
      res.out_blue = best_cnt != 0 ? 16'(sum_b[best] / best_cnt) : 16'd0;
      res.out_alpha = 16'(channel_of(pixel_mem[q.y * 64 + q.x], 3));
      return res;
   endfunction

   // Accepted words update the predictor; result words are checked in order.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         accepted_cnt <= accepted_cnt + 1;
         if (req_word.kind == KIND_LOAD)
            pixel_mem[req_word.y * 64 + req_word.x] =
               {req_word.alpha, req_word.blue, req_word.green, req_word.red};
         else
            painted_expect.push_back(paint_pixel(req_word));
      end
      if (!reset && rsp_strobe) begin
         if (painted_expect.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            failed = 1;
         end else begin
            rsp_type want;
            want = painted_expect.pop_front();
            if (want !== rsp_word) begin
               $display("%0t: mismatch x/y expected %0d/%0d actual %0d/%0d", $time,
                  want.out_x, want.out_y, rsp_word.out_x, rsp_word.out_y);
               $display("%0t:   rgba expected %h %h %h %h actual %h %h %h %h", $time,
                  want.out_red, want.out_green, want.out_blue, want.out_alpha,
                  rsp_word.out_red, rsp_word.out_green, rsp_word.out_blue,
                  rsp_word.out_alpha);
               failed = 1;
            end
         end
      end
   end

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && accepted_cnt == issued_cnt) begin
         // Still waiting for the current word to be taken.
      end else begin
         if (start) issued_cnt <= issued_cnt + 1;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_word <= pending_words.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic logic [15:0] random_channel();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_load(int px, int py);
      req_type w;
      w.kind = KIND_LOAD;
      w.x = 6'(px);
      w.y = 6'(py);
      w.red = random_channel();
      w.green = random_channel();
      w.blue = random_channel();
      w.alpha = random_channel();
      pixel_loaded[py * 64 + px] = 1;
      pending_words.push_back(w);
   endtask

   // Queue a query, first loading any window pixel it would read unwritten.
   task automatic queue_query(int qx, int qy);
      req_type w;
      int wid;
      int hgt;
      int rad;
      wid = cur_width > 64 ? 64 : cur_width;
      hgt = cur_height > 64 ? 64 : cur_height;
      rad = int'(cur_radius);
      for (int wx = qx - rad; wx <= qx + rad; wx++)
         for (int wy = qy - rad; wy <= qy + rad; wy++)
            if (wx >= 0 && wx < wid && wy >= 0 && wy < hgt && !pixel_loaded[wy * 64 + wx])
               queue_load(wx, wy);
      if (!pixel_loaded[qy * 64 + qx]) queue_load(qx, qy);
      w = '0;
      w.kind = KIND_QUERY;
      w.x = 6'(qx);
      w.y = 6'(qy);
      w.red = 16'($urandom);
      w.green = 16'($urandom);
      w.blue = 16'($urandom);
      w.alpha = 16'($urandom);
      pending_words.push_back(w);
   endtask

   // Wait until every word is taken, every result is in and the block is idle.
   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || start || painted_expect.size() != 0 || busy);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_WIDTH:   cur_width = val[6:0];
         CSR_HEIGHT:  cur_height = val[6:0];
         CSR_RADIUS:  cur_radius = val[2:0];
         CSR_LEVELS:  cur_levels = val;
         CSR_SIXTEEN: cur_sixteen = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int w, int h, int r, int l, int s, int nq, int nl);
      int wid;
      int hgt;
      int qx;
      int qy;
      drain();
      write_csr(CSR_WIDTH, 8'(w));
      write_csr(CSR_HEIGHT, 8'(h));
      write_csr(CSR_RADIUS, 8'(r));
      write_csr(CSR_LEVELS, 8'(l));
      write_csr(CSR_SIXTEEN, 8'(s));
      wid = cur_width > 64 ? 64 : cur_width;
      hgt = cur_height > 64 ? 64 : cur_height;
      for (int i = 0; i < nl; i++)
         queue_load($urandom_range(0, 63), $urandom_range(0, 63));
      for (int i = 0; i < nq; i++) begin
         // Mostly centers inside the image, some anywhere in the store.
         if (wid == 0 || hgt == 0 || $urandom_range(0, 4) == 0) begin
            qx = $urandom_range(0, 63);
            qy = $urandom_range(0, 63);
         end else begin
            qx = $urandom_range(0, wid - 1);
            qy = $urandom_range(0, hgt - 1);
         end
         queue_query(qx, qy);
         if ($urandom_range(0, 3) == 0)
            queue_load($urandom_range(0, 63), $urandom_range(0, 63));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      accepted_cnt = 0;
      issued_cnt = 0;
      burst_left = 0;
      gap_left = 0;
      failed = 0;
      for (int i = 0; i < 4096; i++) begin
         pixel_mem[i] = '0;
         pixel_loaded[i] = 0;
      end
      cur_width = 64;
      cur_height = 64;
      cur_radius = 1;
      cur_levels = 30;
      cur_sixteen = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, corner pixels with random channel values.
      queue_query(0, 0);
      queue_query(63, 63);
      queue_query(0, 63);
      queue_query(63, 0);
      queue_query(31, 17);

      // Directed settings: thin images at the largest radius, zero sizes,
      // oversized registers, one-level and full-level binning.
      run_phase(1, 64, 7, 255, 1, 3, 0);
      run_phase(64, 1, 7, 1, 0, 3, 0);
      run_phase(0, 0, 0, 0, 0, 3, 0);
      run_phase(127, 127, 0, 0, 1, 3, 0);
      run_phase(5, 3, 2, 0, 1, 3, 0);

      // Random content under a range of settings, on small images.
      run_phase(8, 8, 2, 30, 0, 30, 5);
      run_phase(6, 10, 3, 100, 1, 25, 3);
      run_phase(10, 6, 1, 8, 0, 40, 4);
      run_phase(12, 3, 4, 3, 1, 20, 2);
      run_phase(4, 4, 5, 200, 1, 15, 2);
      run_phase(6, 6, 6, 60, 0, 15, 3);
      drain();

      if (!failed)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
